/* rtl/grid_local_maximum_finder_top_macros.svh */
// Assertion macros shared by the grid local maximum finder checker.
`ifndef GRID_LOCAL_MAXIMUM_FINDER_TOP_MACROS_SVH
`define GRID_LOCAL_MAXIMUM_FINDER_TOP_MACROS_SVH

// Consequent checked at the same clock edge as the antecedent, outside reset.
`define GLMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked at the clock edge after the antecedent, outside reset.
`define GLMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/glmf_pkg.sv */
// Shared types and constants for the grid local maximum finder.
package glmf_pkg;

  // Default sizes of the grid and of one cell value.
  localparam int unsigned MaxColsDef   = 32;
  localparam int unsigned MaxRowsDef   = 1024;
  localparam int unsigned ValueBitsDef = 16;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned RowCountW = 11;
  localparam int unsigned ColCountW = 6;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_ROW_COUNT = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_COL_COUNT = 1'd1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_FRD,
    ST_FDEC,
    ST_LAST
  } glmf_state_e;

  // Source of a result loaded into the output register.
  typedef enum logic {
    OUT_NEW,
    OUT_PEND
  } out_src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     item_load;
    logic     flush_rd;
    logic     win_adv;
    logic     win_reload;
    logic     col_clear;
    logic     col_inc;
    logic     flush;
    logic     pend_load;
    logic     pend_clear;
    logic     out_load;
    out_src_e out_src;
    logic     out_last;
  } glmf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic peak;
    logic row_first;
    logic row_end;
    logic frame_end;
    logic col_last;
    logic out_free;
    logic pend_valid;
  } glmf_status_t;

endpackage

/* rtl/glmf_ctrl.sv */
// Controller state machine that sequences decisions and the last-row scan.
module glmf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  glmf_pkg::glmf_status_t status_i,
  output glmf_pkg::glmf_cmd_t    cmd_o
);

  glmf_pkg::glmf_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glmf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.out_src    = glmf_pkg::OUT_NEW;
    unique case (state_q)
      glmf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = glmf_pkg::ST_DEC;
        end
      end
      glmf_pkg::ST_DEC: begin
        if (status_i.frame_end) begin
          // The final cell: hold its result back until the scan shows whether it is last.
          cmd_o.pend_load  = status_i.peak;
          cmd_o.win_reload = 1'b1;
          cmd_o.col_clear  = 1'b1;
          state_d          = glmf_pkg::ST_FRD;
        end else if (!(status_i.peak && !status_i.row_first && !status_i.out_free)) begin
          cmd_o.out_load   = status_i.peak && !status_i.row_first;
          cmd_o.out_src    = glmf_pkg::OUT_NEW;
          cmd_o.out_last   = 1'b1;
          cmd_o.win_reload = status_i.row_end;
          cmd_o.win_adv    = !status_i.row_end;
          state_d          = glmf_pkg::ST_IDLE;
        end
      end
      glmf_pkg::ST_FRD: begin
        cmd_o.flush_rd = 1'b1;
        state_d        = glmf_pkg::ST_FDEC;
      end
      glmf_pkg::ST_FDEC: begin
        cmd_o.flush = 1'b1;
        if (!(status_i.peak && status_i.pend_valid && !status_i.out_free)) begin
          // A new peak pushes the held one out as a non-final result.
          cmd_o.out_load  = status_i.peak && status_i.pend_valid;
          cmd_o.out_src   = glmf_pkg::OUT_PEND;
          cmd_o.out_last  = 1'b0;
          cmd_o.pend_load = status_i.peak;
          cmd_o.win_adv   = 1'b1;
          if (status_i.col_last) begin
            state_d = glmf_pkg::ST_LAST;
          end else begin
            cmd_o.col_inc = 1'b1;
            state_d       = glmf_pkg::ST_FRD;
          end
        end
      end
      glmf_pkg::ST_LAST: begin
        if (!status_i.pend_valid) begin
          state_d = glmf_pkg::ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_src    = glmf_pkg::OUT_PEND;
          cmd_o.out_last   = 1'b1;
          cmd_o.pend_clear = 1'b1;
          state_d          = glmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = glmf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/glmf_dp.sv */
// Datapath: configuration, line banks, comparison window, held result and output register.
module glmf_dp #(
  parameter int unsigned MAX_COLS   = glmf_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS   = glmf_pkg::MaxRowsDef,
  parameter int unsigned VALUE_BITS = glmf_pkg::ValueBitsDef,
  localparam int unsigned RowW      = $clog2(MAX_ROWS),
  localparam int unsigned ColW      = $clog2(MAX_COLS)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [glmf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [glmf_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic signed [VALUE_BITS-1:0]    pixel_i,
  input  glmf_pkg::glmf_cmd_t             cmd_i,
  output glmf_pkg::glmf_status_t          status_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [RowW-1:0]                 peak_row_o,
  output logic [ColW-1:0]                 peak_col_o,
  output logic                            last_o
);

  logic [glmf_pkg::RowCountW-1:0] row_cnt;
  logic [glmf_pkg::ColCountW-1:0] col_cnt;
  logic [RowW-1:0] rows_last_q, rows_last_d;
  logic [ColW-1:0] cols_last_q, cols_last_d;

  logic [RowW-1:0] pos_row_q;
  logic [ColW-1:0] pos_col_q;
  logic            row_end_in, frame_end_in;

  logic [1:0] cur_sel_q, prev_sel_q, old_sel_q;

  logic signed [VALUE_BITS-1:0] pixel_q, cur0_q;
  logic [RowW-1:0]              item_row_q;
  logic [ColW-1:0]              item_col_q;
  logic                         item_row_end_q, item_frame_end_q;

  logic                         rd_en;
  logic [1:0]                   sel_a, sel_b, sel_a_q, sel_b_q;
  logic [ColW-1:0]              addr_a, addr_b;
  logic signed [VALUE_BITS-1:0] bank_rd_q [3];
  logic signed [VALUE_BITS-1:0] rd_a, rd_b;

  logic signed [VALUE_BITS-1:0] pm_q, pl_q;
  logic                         has_above, left_ok, right_ok, peak;
  logic [RowW-1:0]              peak_row;

  logic            pend_valid_q;
  logic [RowW-1:0] pend_row_q;
  logic [ColW-1:0] pend_col_q;
  logic            out_valid_q;

  // Saturate the written counts into last-index form.
  assign row_cnt = cfg_data_i[glmf_pkg::RowCountW-1:0];
  assign col_cnt = cfg_data_i[glmf_pkg::ColCountW-1:0];

  always_comb begin
    if (row_cnt < glmf_pkg::RowCountW'(2)) begin
      rows_last_d = RowW'(1);
    end else if (32'(row_cnt) > MAX_ROWS) begin
      rows_last_d = RowW'(MAX_ROWS - 1);
    end else begin
      rows_last_d = RowW'(row_cnt - glmf_pkg::RowCountW'(1));
    end
    if (col_cnt < glmf_pkg::ColCountW'(2)) begin
      cols_last_d = ColW'(1);
    end else if (32'(col_cnt) > MAX_COLS) begin
      cols_last_d = ColW'(MAX_COLS - 1);
    end else begin
      cols_last_d = ColW'(col_cnt - glmf_pkg::ColCountW'(1));
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_last_q <= RowW'(1);
      cols_last_q <= ColW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        glmf_pkg::REG_ROW_COUNT: rows_last_q <= rows_last_d;
        glmf_pkg::REG_COL_COUNT: cols_last_q <= cols_last_d;
        default: ;
      endcase
    end
  end

  // Frame position of the next cell; any configuration write restarts the frame.
  assign row_end_in   = (pos_col_q == cols_last_q);
  assign frame_end_in = row_end_in && (pos_row_q == rows_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_row_q <= '0;
      pos_col_q <= '0;
    end else if (cfg_we_i) begin
      pos_row_q <= '0;
      pos_col_q <= '0;
    end else if (cmd_i.item_load) begin
      if (frame_end_in) begin
        pos_row_q <= '0;
        pos_col_q <= '0;
      end else if (row_end_in) begin
        pos_row_q <= pos_row_q + RowW'(1);
        pos_col_q <= '0;
      end else begin
        pos_col_q <= pos_col_q + ColW'(1);
      end
    end
  end

  // Bank roles rotate at each row end but the last one of a frame, instead of copying rows.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_sel_q  <= 2'd0;
      prev_sel_q <= 2'd1;
      old_sel_q  <= 2'd2;
    end else if (cmd_i.item_load && row_end_in && !frame_end_in) begin
      old_sel_q  <= prev_sel_q;
      prev_sel_q <= cur_sel_q;
      cur_sel_q  <= old_sel_q;
    end
  end

  // Item registers and the scan column.
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      pixel_q          <= pixel_i;
      item_row_q       <= pos_row_q;
      item_col_q       <= pos_col_q;
      item_row_end_q   <= row_end_in;
      item_frame_end_q <= frame_end_in;
      if (pos_col_q == '0) begin
        cur0_q <= pixel_i;
      end
    end else if (cmd_i.col_clear) begin
      item_col_q <= '0;
    end else if (cmd_i.col_inc) begin
      item_col_q <= item_col_q + ColW'(1);
    end
  end

  // Read requests: above-cell read on port A, right-neighbour read on port B.
  assign rd_en  = cmd_i.item_load || cmd_i.flush_rd;
  assign sel_a  = cmd_i.item_load ? old_sel_q : prev_sel_q;
  assign sel_b  = cmd_i.item_load ? prev_sel_q : cur_sel_q;
  assign addr_a = cmd_i.item_load ? pos_col_q : item_col_q;
  assign addr_b = (addr_a == cols_last_q) ? addr_a : addr_a + ColW'(1);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      sel_a_q <= sel_a;
      sel_b_q <= sel_b;
    end
  end

  // Three line banks, each with one write and one registered read.
  for (genvar k = 0; k < 3; k++) begin : g_bank
    logic [VALUE_BITS-1:0] mem [MAX_COLS];
    logic [ColW-1:0]       rd_addr;

    assign rd_addr = (sel_a == 2'(k)) ? addr_a : addr_b;

    always_ff @(posedge clk_i) begin
      if (cmd_i.item_load && (cur_sel_q == 2'(k))) begin
        mem[pos_col_q] <= pixel_i;
      end
      if (rd_en) begin
        bank_rd_q[k] <= mem[rd_addr];
      end
    end
  end

  // Route the read data back by the roles used at issue time.
  always_comb begin
    case (sel_a_q)
      2'd0:    rd_a = bank_rd_q[0];
      2'd1:    rd_a = bank_rd_q[1];
      default: rd_a = bank_rd_q[2];
    endcase
    case (sel_b_q)
      2'd0:    rd_b = bank_rd_q[0];
      2'd1:    rd_b = bank_rd_q[1];
      default: rd_b = bank_rd_q[2];
    endcase
  end

  // Sliding window over the row under decision: left and middle cells.
  always_ff @(posedge clk_i) begin
    if (cmd_i.win_reload) begin
      pm_q <= cur0_q;
    end else if (cmd_i.win_adv) begin
      pl_q <= pm_q;
      pm_q <= rd_b;
    end
  end

  // Peak test against the in-grid four neighbours.
  assign has_above = cmd_i.flush || (item_row_q > RowW'(1));
  assign left_ok   = (item_col_q != '0);
  assign right_ok  = (item_col_q != cols_last_q);
  assign peak      = (!has_above || (pm_q >= rd_a)) &&
                     (cmd_i.flush || (pm_q >= pixel_q)) &&
                     (!left_ok || (pm_q >= pl_q)) &&
                     (!right_ok || (pm_q >= rd_b));
  assign peak_row  = cmd_i.flush ? item_row_q : item_row_q - RowW'(1);

  // Held result, released once the next one or the end of the scan is known.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.pend_load) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.pend_clear) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_load) begin
      pend_row_q <= peak_row;
      pend_col_q <= item_col_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      last_o <= cmd_i.out_last;
      if (cmd_i.out_src == glmf_pkg::OUT_PEND) begin
        peak_row_o <= pend_row_q;
        peak_col_o <= pend_col_q;
      end else begin
        peak_row_o <= peak_row;
        peak_col_o <= item_col_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // Status towards the controller.
  assign status_o.peak       = peak;
  assign status_o.row_first  = (item_row_q == '0);
  assign status_o.row_end    = item_row_end_q;
  assign status_o.frame_end  = item_frame_end_q;
  assign status_o.col_last   = right_ok == 1'b0;
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.pend_valid = pend_valid_q;

endmodule

/* rtl/grid_local_maximum_finder_top.sv */
// Grid local maximum finder: a cell arriving in row r decides the cell above it, which is
// reported when it is at least each of its in-grid up, down, left and right neighbours. Each
// cell is stored, starting two line-bank reads, in the idle state and compared in the decide
// state; no new cell is taken before that, and the compare waits only while the output register
// holds an untaken result that a new one would replace. The final cell of a frame then scans
// the whole last row, alternating a read state and a compare state for each column, and then
// releases the held result. Each of the three rotating line banks has a single read port. A result
// is marked last when it is the final one that its input cell causes. Writing either count
// restarts the frame at row 0, column 0.
module grid_local_maximum_finder_top #(
  parameter int unsigned MAX_COLS   = glmf_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS   = glmf_pkg::MaxRowsDef,
  parameter int unsigned VALUE_BITS = glmf_pkg::ValueBitsDef,
  localparam int unsigned RowW      = $clog2(MAX_ROWS),
  localparam int unsigned ColW      = $clog2(MAX_COLS),
  localparam int unsigned InDataW   = ((VALUE_BITS + 7) / 8) * 8,
  localparam int unsigned OutDataW  = ((RowW + ColW + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes.
  input  logic                          cfg_we_i,
  input  logic [glmf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [glmf_pkg::CfgDataW-1:0] cfg_data_i,
  // Cell stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [InDataW-1:0]            s_axis_tdata,   // pixel_value
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OutDataW-1:0]           m_axis_tdata,   // peak_row, peak_col
  output logic                          m_axis_tlast    // last_of_run
);

  glmf_pkg::glmf_cmd_t    cmd;
  glmf_pkg::glmf_status_t status;
  logic [RowW-1:0]        peak_row;
  logic [ColW-1:0]        peak_col;

  // Controller.
  glmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  glmf_dp #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_i     (s_axis_tdata[VALUE_BITS-1:0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .peak_row_o  (peak_row),
    .peak_col_o  (peak_col),
    .last_o      (m_axis_tlast)
  );

  // Pack the result fields, row index in the lowest bits.
  assign m_axis_tdata = OutDataW'({peak_col, peak_row});

endmodule

/* rtl/glmf_checker.sv */
// Port-level checker for the grid local maximum finder, bound to the top level.
`include "grid_local_maximum_finder_top_macros.svh"

module glmf_checker #(
  parameter int unsigned OutDataW = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  // A stalled result keeps its fields.
  `GLMF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

  // An accepted cell always makes the block busy; two cells are never accepted back to back.
  `GLMF_ASSERT_NEXT(a_in_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "cell accepted in the cycle after another")

  // A fresh result is only raised from a busy state, never straight from the idle state.
  `GLMF_ASSERT_NOW(a_out_from_busy, $rose(m_axis_tvalid), !$past(s_axis_tready), "result raised while the block was idle")

endmodule

bind grid_local_maximum_finder_top glmf_checker #(
  .OutDataW (OutDataW)
) u_glmf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the grid local maximum finder, with its own peak predictor.
module testbench;

  localparam int unsigned MaxCols      = glmf_pkg::MaxColsDef;
  localparam int unsigned MaxRows      = glmf_pkg::MaxRowsDef;
  localparam int unsigned ValBits      = glmf_pkg::ValueBitsDef;
  localparam int unsigned RowW         = $clog2(MaxRows);
  localparam int unsigned ColW         = $clog2(MaxCols);
  localparam int unsigned InDataW      = ((ValBits + 7) / 8) * 8;
  localparam int unsigned OutDataW     = ((RowW + ColW + 7) / 8) * 8;
  // The final cell of a frame keeps the block busy while it scans every column of the last row.
  localparam int unsigned SettleCycles = 2 * MaxCols + 16;
  localparam int unsigned RandomItems  = 110;
  localparam int unsigned CycleLimit   = 400000;

  typedef logic signed [ValBits-1:0] cell_t;
  typedef cell_t line_t [MaxCols];

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
  } peak_t;

  // Ways of filling a frame with cell values.
  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_TIES,
    FILL_FLAT,
    FILL_EXTREME
  } fill_e;

  localparam cell_t MinCell = {1'b1, {(ValBits - 1){1'b0}}};
  localparam cell_t MaxCell = {1'b0, {(ValBits - 1){1'b1}}};

  // Tracks the grid position and line contents, and holds the peaks still to be reported.
  class peak_scoreboard;
    line_t                          older;
    line_t                          prev;
    line_t                          cur;
    int unsigned                    row_pos;
    int unsigned                    col_pos;
    logic [glmf_pkg::RowCountW-1:0] row_reg;
    logic [glmf_pkg::ColCountW-1:0] col_reg;
    peak_t                          pending[$];
    int unsigned                    errors;

    function new();
      row_pos = 0;
      col_pos = 0;
      row_reg = 2;
      col_reg = 2;
      errors  = 0;
    endfunction

    function int unsigned rows_eff();
      if (row_reg < 2) return 2;
      if (row_reg > MaxRows) return MaxRows;
      return row_reg;
    endfunction

    function int unsigned cols_eff();
      if (col_reg < 2) return 2;
      if (col_reg > MaxCols) return MaxCols;
      return col_reg;
    endfunction

    // A register write always restarts the frame; line contents are kept.
    function void write_reg(logic [glmf_pkg::CfgIdxW-1:0]  idx,
                            logic [glmf_pkg::CfgDataW-1:0] data);
      case (idx)
        glmf_pkg::REG_ROW_COUNT: begin
          row_reg = data[glmf_pkg::RowCountW-1:0];
        end
        glmf_pkg::REG_COL_COUNT: begin
          col_reg = data[glmf_pkg::ColCountW-1:0];
        end
        default: begin
        end
      endcase
      row_pos = 0;
      col_pos = 0;
    endfunction

    // True when mid[c] is at least every in-grid neighbour that is given.
    function bit dominates(line_t mid, line_t above, bit use_above, cell_t below,
                           bit use_below, int unsigned c, int unsigned cols);
      cell_t v;
      v = mid[c];
      if (use_above && v < above[c]) return 1'b0;
      if (use_below && v < below) return 1'b0;
      if (c > 0 && v < mid[c - 1]) return 1'b0;
      if (c + 1 < cols && v < mid[c + 1]) return 1'b0;
      return 1'b1;
    endfunction

    function peak_t make_peak(int unsigned r, int unsigned c);
      peak_t p;
      p.row  = RowW'(r);
      p.col  = ColW'(c);
      p.last = 1'b0;
      return p;
    endfunction

    // An accepted cell decides the cell above it, and the final cell the whole last row.
    function void note_cell(logic [InDataW-1:0] data);
      int unsigned rows;
      int unsigned cols;
      int unsigned r;
      int unsigned c;
      cell_t       v;
      peak_t       batch[$];
      rows = rows_eff();
      cols = cols_eff();
      r    = row_pos;
      c    = col_pos;
      if (r >= rows || c >= cols) begin
        r = 0;
        c = 0;
      end
      v      = data[ValBits-1:0];
      cur[c] = v;
      if (r >= 1 && dominates(prev, older, r >= 2, v, 1'b1, c, cols)) begin
        batch.push_back(make_peak(r - 1, c));
      end
      if (r + 1 == rows && c + 1 == cols) begin
        for (int unsigned cc = 0; cc < cols; cc++) begin
          if (dominates(cur, prev, 1'b1, '0, 1'b0, cc, cols)) begin
            batch.push_back(make_peak(r, cc));
          end
        end
        row_pos = 0;
        col_pos = 0;
      end else if (c + 1 == cols) begin
        older   = prev;
        prev    = cur;
        row_pos = r + 1;
        col_pos = 0;
      end else begin
        row_pos = r;
        col_pos = c + 1;
      end
      foreach (batch[i]) begin
        batch[i].last = (i == batch.size() - 1);
        pending.push_back(batch[i]);
      end
    endfunction

    function void check_peak(logic [RowW-1:0] row, logic [ColW-1:0] col, logic last);
      peak_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: peak_row %0d, peak_col %0d", row, col);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (row !== want.row) begin
        $error("peak_row: expected %0d, actual %0d", want.row, row);
        errors++;
      end
      if (col !== want.col) begin
        $error("peak_col: expected %0d, actual %0d", want.col, col);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [glmf_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [glmf_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [InDataW-1:0]            s_axis_tdata;   // pixel_value
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [OutDataW-1:0]           m_axis_tdata;   // peak_row, peak_col
  logic                          m_axis_tlast;   // last_of_run

  int unsigned    src_idle_pct = 0;
  int unsigned    snk_stall_pct = 0;
  int unsigned    cycle_count = 0;
  peak_scoreboard sb = new();

  grid_local_maximum_finder_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock with a 4 ns period.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Result sink with random back-pressure.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Observe both streams: a result transaction is checked before a new cell is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_peak(m_axis_tdata[RowW-1:0], m_axis_tdata[RowW+ColW-1:RowW], m_axis_tlast);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_cell(s_axis_tdata);
      end
    end
  end

  // Guard against a stalled run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** grid_local_maximum_finder_top: FAILED **");
      $finish;
    end
  end

  function automatic void set_idle(int unsigned mode);
    case (mode)
      1: begin
        src_idle_pct  = 87;
        snk_stall_pct = 0;
      end
      2: begin
        src_idle_pct  = 0;
        snk_stall_pct = 87;
      end
      3: begin
        src_idle_pct  = 30;
        snk_stall_pct = 30;
      end
      default: begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
    endcase
  endfunction

  function automatic cell_t pick_value(fill_e fill, cell_t flat);
    case (fill)
      FILL_TIES: return cell_t'(int'($urandom_range(4)) - 2);
      FILL_FLAT: return flat;
      FILL_EXTREME: begin
        case ($urandom_range(2))
          0: return MinCell;
          1: return MaxCell;
          default: return cell_t'($urandom);
        endcase
      end
      default: return cell_t'($urandom);
    endcase
  endfunction

  // Offer one cell, with random gaps before it, and wait for its transaction.
  task automatic send_cell(input cell_t v);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop sending, wait for every outstanding peak, then let the final scan finish.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [glmf_pkg::CfgIdxW-1:0]  idx,
                           input logic [glmf_pkg::CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Upper data bits above the column count are random, as the register ignores them.
  task automatic configure(input int unsigned rows_data, input int unsigned cols_data,
                           input bit do_rows, input bit do_cols);
    quiesce();
    if (do_rows) begin
      write_reg(glmf_pkg::REG_ROW_COUNT, glmf_pkg::CfgDataW'(rows_data));
    end
    if (do_cols) begin
      write_reg(glmf_pkg::REG_COL_COUNT, glmf_pkg::CfgDataW'(cols_data % 64) |
                (glmf_pkg::CfgDataW'($urandom) << glmf_pkg::ColCountW));
    end
  endtask

  task automatic send_frame(input int unsigned count, input fill_e fill);
    cell_t flat;
    flat = cell_t'($urandom);
    for (int unsigned i = 0; i < count; i++) begin
      send_cell(pick_value(fill, flat));
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned frame_no;
    int unsigned rows_data;
    int unsigned cols_data;
    int unsigned total;
    int unsigned count;
    bit          do_rows;
    bit          do_cols;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = glmf_pkg::REG_ROW_COUNT;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idle(0);

    // Reset size of two by two, with the extreme values on the diagonals.
    send_cell(MinCell);
    send_cell(MaxCell);
    send_cell(MaxCell);
    send_cell(MinCell);

    // A flat grid: every cell ties with all its neighbours and is a peak.
    configure(2, 3, 1'b1, 1'b1);
    repeat (6) send_cell('0);

    // Counts below the minimum saturate to two rows and two columns.
    configure(0, 1, 1'b1, 1'b1);
    send_cell(cell_t'(7));
    send_cell(cell_t'(-1));
    send_cell(cell_t'(-1));
    send_cell(cell_t'(7));

    // A write in mid-frame restarts the frame at the first cell.
    configure(1, 3, 1'b1, 1'b1);
    send_frame(4, FILL_RANDOM);
    configure(0, 3, 1'b0, 1'b1);
    send_frame(6, FILL_EXTREME);

    // Widest grid, columns saturated: a flat top last row gives the longest run of peaks.
    set_idle(2);
    configure(2, 63, 1'b1, 1'b1);
    send_frame(MaxCols, FILL_RANDOM);
    repeat (MaxCols) send_cell(MaxCell);

    // Rows saturated; the frame is cut short by the next register write.
    set_idle(0);
    configure(2047, 2, 1'b1, 1'b1);
    send_frame(12, FILL_RANDOM);

    // Random frames, mostly small, some cut short by the next register write.
    sent     = 0;
    frame_no = 0;
    while (sent < RandomItems) begin
      set_idle(frame_no % 4);
      if ($urandom_range(99) < 80) begin
        rows_data = $urandom_range(6, 2);
      end else begin
        rows_data = $urandom_range(3);
      end
      case ($urandom_range(9))
        0, 1: cols_data = ($urandom_range(1) != 0) ? $urandom_range(1) : $urandom_range(63, 33);
        2:    cols_data = $urandom_range(MaxCols, 9);
        default: cols_data = $urandom_range(8, 2);
      endcase
      do_rows = ($urandom_range(2) != 0);
      do_cols = !do_rows || ($urandom_range(2) != 0);
      configure(rows_data, cols_data, do_rows, do_cols);
      total = sb.rows_eff() * sb.cols_eff();
      count = total;
      if ($urandom_range(99) < 15) begin
        count = $urandom_range(total - 1, 1);
      end
      send_frame(count, fill_e'($urandom_range(3)));
      sent += count;
      frame_no++;
    end

    quiesce();
    if (sb.errors == 0) begin
      $display("** grid_local_maximum_finder_top: PASSED **");
    end else begin
      $display("** grid_local_maximum_finder_top: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/glmf_pkg.sv
rtl/glmf_ctrl.sv
rtl/glmf_dp.sv
rtl/grid_local_maximum_finder_top.sv
rtl/glmf_checker.sv
test/testbench.sv
